// ===== rtl/rbs_pkg.sv =====
// package: payload types, constants and helpers for the ray-box slab test
`default_nettype none
package rbs_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_AXES       = 3;

    localparam logic signed [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic signed [DATA_W-1:0] origin_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
        logic signed [DATA_W-1:0] box_min_x;
        logic signed [DATA_W-1:0] box_min_y;
        logic signed [DATA_W-1:0] box_min_z;
        logic signed [DATA_W-1:0] box_max_x;
        logic signed [DATA_W-1:0] box_max_y;
        logic signed [DATA_W-1:0] box_max_z;
    } ray_box_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] entry_distance;
        logic                     hit;
    } result_t;

    // sideband carried along each divider pipeline
    typedef struct packed {
        logic neg;
        logic den_zero;
        logic num_zero;
        logic num_pos;
    } div_tag_t;

endpackage
`default_nettype wire

// ===== rtl/ray_box_slab_test.sv =====
// top level: three axis lanes, interval merge and output register
`default_nettype none
// stages: divider input, divider steps, lane order, output register (default Q16.16)
// throughput: one item per cycle; each divider pipeline retires one quotient per cycle
// the whole pipeline advances together and holds while the output is stalled
// reset: aresetn synchronous active low clears the valid bits of all stages
module ray_box_slab_test #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rbs_pkg::ray_box_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rbs_pkg::result_t       m_data
);
    import rbs_pkg::*;

    // divider: 1 input + (33+FRAC_BITS) steps, then order, merge
    localparam int LAT = DATA_W + FRAC_BITS + 4;

    logic [LAT-1:0] vld_reg;
    logic           en;

    logic signed [DATA_W-1:0] org   [NUM_AXES];
    logic signed [DATA_W-1:0] dirv  [NUM_AXES];
    logic signed [DATA_W-1:0] bmin  [NUM_AXES];
    logic signed [DATA_W-1:0] bmax  [NUM_AXES];
    logic signed [DATA_W-1:0] tn    [NUM_AXES];
    logic signed [DATA_W-1:0] tf    [NUM_AXES];

    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    result_t                  res_next;

    // pipeline advances unless the last stage is full and stalled
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    assign org  = '{s_data.origin_x, s_data.origin_y, s_data.origin_z};
    assign dirv = '{s_data.dir_x, s_data.dir_y, s_data.dir_z};
    assign bmin = '{s_data.box_min_x, s_data.box_min_y, s_data.box_min_z};
    assign bmax = '{s_data.box_max_x, s_data.box_max_y, s_data.box_max_z};

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk(aclk), .en(en),
            .origin(org[a]), .dir(dirv[a]), .bmin(bmin[a]), .bmax(bmax[a]),
            .t_near(tn[a]), .t_far(tf[a])
        );
    end

    always_comb begin
        lo = tn[0];
        hi = tf[0];
        for (int a = 1; a < NUM_AXES; a++) begin
            if (tn[a] > lo) lo = tn[a];
            if (tf[a] < hi) hi = tf[a];
        end
        res_next.hit            = ~(lo > hi);
        res_next.entry_distance = res_next.hit ? lo : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) m_data <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rbs_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with saturation
`default_nettype none
module rbs_div #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [rbs_pkg::DATA_W:0]   num,
    input  wire logic signed [rbs_pkg::DATA_W-1:0] den,
    input  wire logic signed [rbs_pkg::DATA_W-1:0] on_plane,
    output logic signed [rbs_pkg::DATA_W-1:0]      quot
);
    import rbs_pkg::*;

    // numerator magnitude up to 2^32, shifted by FRAC_BITS
    localparam int NW = DATA_W + 1 + FRAC_BITS;
    localparam int DW = DATA_W + 1;
    localparam int STAGES = NW;

    logic [NW-1:0]        n_reg   [STAGES+1];
    logic [DW-1:0]        d_reg   [STAGES+1];
    logic [DW:0]          r_reg   [STAGES+1];
    logic [NW-1:0]        q_reg   [STAGES+1];
    div_tag_t             tag_reg [STAGES+1];
    logic [DATA_W-1:0]    op_reg  [STAGES+1];

    logic [DATA_W:0]      nmag;
    logic [DATA_W:0]      dmag;

    always_comb begin
        nmag = num[DATA_W] ? (DATA_W+1)'(0) - num : num;
        dmag = den[DATA_W-1] ? (DATA_W+1)'(0) - {den[DATA_W-1], den}
                             : {1'b0, den};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]            <= {nmag, {FRAC_BITS{1'b0}}};
            d_reg[0]            <= dmag;
            r_reg[0]            <= '0;
            q_reg[0]            <= '0;
            op_reg[0]           <= on_plane;
            tag_reg[0].neg      <= num[DATA_W] ^ den[DATA_W-1];
            tag_reg[0].den_zero <= (den == '0);
            tag_reg[0].num_zero <= (num == '0);
            tag_reg[0].num_pos  <= ~num[DATA_W] && (num != '0);
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DW:0] r_shift;
        logic [DW:0] r_sub;
        always_comb begin
            r_shift = {r_reg[s][DW-1:0], n_reg[s][NW-1]};
            r_sub   = r_shift - {1'b0, d_reg[s]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[s+1]   <= {n_reg[s][NW-2:0], 1'b0};
                d_reg[s+1]   <= d_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                op_reg[s+1]  <= op_reg[s];
                if (!r_sub[DW]) begin
                    r_reg[s+1] <= r_sub;
                    q_reg[s+1] <= {q_reg[s][NW-2:0], 1'b1};
                end else begin
                    r_reg[s+1] <= r_shift;
                    q_reg[s+1] <= {q_reg[s][NW-2:0], 1'b0};
                end
            end
        end
    end

    logic [NW-1:0] q_fin;
    div_tag_t      t_fin;
    logic          big_pos;
    logic          big_neg;

    always_comb begin
        q_fin   = q_reg[STAGES];
        t_fin   = tag_reg[STAGES];
        big_pos = (q_fin > NW'(SAT_POS));
        big_neg = (q_fin >= NW'({1'b1, {(DATA_W-1){1'b0}}}));
        if (t_fin.den_zero) begin
            if (t_fin.num_zero)     quot = op_reg[STAGES];
            else if (t_fin.num_pos) quot = SAT_POS;
            else                    quot = SAT_NEG;
        end else if (t_fin.neg) begin
            quot = big_neg ? SAT_NEG : DATA_W'(DATA_W'(0) - q_fin[DATA_W-1:0]);
        end else begin
            quot = big_pos ? SAT_POS : q_fin[DATA_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rbs_lane.sv =====
// one axis lane: numerators, two dividers and ordering of the slab interval
`default_nettype none
module rbs_lane #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [rbs_pkg::DATA_W-1:0] origin,
    input  wire logic signed [rbs_pkg::DATA_W-1:0] dir,
    input  wire logic signed [rbs_pkg::DATA_W-1:0] bmin,
    input  wire logic signed [rbs_pkg::DATA_W-1:0] bmax,
    output logic signed [rbs_pkg::DATA_W-1:0]      t_near,
    output logic signed [rbs_pkg::DATA_W-1:0]      t_far
);
    import rbs_pkg::*;

    logic signed [DATA_W:0]   num0;
    logic signed [DATA_W:0]   num1;
    logic signed [DATA_W-1:0] t0;
    logic signed [DATA_W-1:0] t1;

    assign num0 = {bmin[DATA_W-1], bmin} - {origin[DATA_W-1], origin};
    assign num1 = {bmax[DATA_W-1], bmax} - {origin[DATA_W-1], origin};

    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .aclk(aclk), .en(en),
        .num(num0), .den(dir), .on_plane(SAT_NEG), .quot(t0)
    );
    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .aclk(aclk), .en(en),
        .num(num1), .den(dir), .on_plane(SAT_POS), .quot(t1)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            t_near <= (t0 > t1) ? t1 : t0;
            t_far  <= (t0 > t1) ? t0 : t1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rbs_checker.sv =====
// port-level checker for the ray-box slab test, bound to the top level
`default_nettype none
module rbs_checker (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire rbs_pkg::result_t m_data
);
    import rbs_pkg::*;

    // a miss always reports zero distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |-> (m_data.entry_distance == '0))
        else $error("miss with nonzero distance");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // input is taken whenever the output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with output free");

    // no result shortly after reset
    a_no_early: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result right after reset");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
